// ----- hdl/msft_pkg.sv -----
`default_nettype none
package msft_pkg;

   localparam int GroupsDefault  = 4;
   localparam int SourcesDefault = 8;

   typedef enum logic [2:0] {
      KIND_FILTER = 3'd0,
      KIND_CREATE = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_ADD    = 3'd3,
      KIND_REMOVE = 3'd4,
      KIND_MODE   = 3'd5
   } kind_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture request, reset scan
      logic grp_step;   // advance group pointer
      logic src_clear;  // restart source scan for the current group
      logic src_step;   // advance source pointer
      logic shift_step; // move one source down during remove
      logic commit;     // apply group update / finish request
      logic rsp_load;   // capture result into output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [2:0] kind;
      logic       grp_last;    // group pointer at last group
      logic       grp_match;   // current group valid and address equal
      logic       src_done;    // source pointer reached count
      logic       src_match;   // current source equals request source
      logic       slot_ok;     // request slot in range
      logic       shift_done;  // shift pointer reached count
   } sts_type;

endpackage
`default_nettype wire

// ----- hdl/msft_ctrl.sv -----
`default_nettype none
module msft_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire msft_pkg::sts_type sts,
   output msft_pkg::cmd_type     cmd
);
   import msft_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_GROUP  = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_SEARCH = 7'b0001000,
      ST_SHIFT  = 7'b0010000,
      ST_DONE   = 7'b0100000,
      ST_WAIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequence one request: group walk for filter, source search for add/remove, shift after a remove hit
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GROUP;
            end
         end
         ST_GROUP: begin
            if (sts.kind == KIND_FILTER) begin
               if (sts.grp_match) begin
                  cmd.src_clear = 1'b1;
                  state_in = ST_SCAN;
               end else if (sts.grp_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.grp_step = 1'b1;
               end
            end else if ((sts.kind == KIND_ADD || sts.kind == KIND_REMOVE) && sts.slot_ok) begin
               cmd.src_clear = 1'b1;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            // scan stops at a match or at the count
            if (sts.src_done || sts.src_match) begin
               if (sts.grp_last) state_in = ST_DONE;
               else begin
                  cmd.grp_step = 1'b1;
                  state_in = ST_GROUP;
               end
            end else begin
               cmd.src_step = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (sts.src_done) state_in = ST_DONE;
            else if (sts.src_match) begin
               state_in = (sts.kind == KIND_REMOVE) ? ST_SHIFT : ST_DONE;
            end else cmd.src_step = 1'b1;
         end
         ST_SHIFT: begin
            if (sts.shift_done) state_in = ST_DONE;
            else cmd.shift_step = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid) else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready) else $error("busy not held");
endmodule
`default_nettype wire

// ----- hdl/msft_dp.sv -----
`default_nettype none
module msft_dp #(
   parameter int GROUPS  = msft_pkg::GroupsDefault,
   parameter int SOURCES = msft_pkg::SourcesDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        req_kind,
   input  wire logic [31:0]       req_group_address,
   input  wire logic [31:0]       req_source_address,
   input  wire logic [1:0]        req_group_slot,
   input  wire logic              req_filter_mode,
   input  wire msft_pkg::cmd_type cmd,
   output msft_pkg::sts_type      sts,
   output logic                   rsp_accept,
   output logic                   rsp_status,
   output logic                   rsp_hit,
   output logic [1:0]             rsp_slot_out
);
   import msft_pkg::*;

   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int CW = $clog2(SOURCES + 1);
   localparam int AW = GW + SW;

   // group table in flip-flops, source lists in a memory
   logic [GROUPS-1:0] valid_ff;
   logic [GROUPS-1:0] mode_ff;
   logic [31:0]       gaddr_ff [GROUPS];
   logic [CW-1:0]     count_ff [GROUPS];
   logic [31:0]       src_mem  [GROUPS*SOURCES];

   // captured request
   logic [2:0]  kind_ff;
   logic [31:0] ga_ff, sa_ff;
   logic [1:0]  slot_ff;
   logic        fm_ff;

   logic [GW-1:0] gp_ff;   // group pointer
   logic [CW-1:0] sp_ff;   // source pointer (one ahead of read data)
   logic          rd_ok_ff; // read data belongs to sp_ff-1
   logic [31:0]   rd_ff;
   logic          accept_ff, hit_ff;
   logic [1:0]    hslot_ff;
   logic          found_ff;
   logic          scan_ff;  // filter scan of one group in progress

   logic [GW-1:0] cur_g;
   logic [CW-1:0] cur_n;
   logic          slot_ok;
   logic [GW-1:0] free_g;
   logic          free_ok;
   logic          verdict;

   assign slot_ok = ({30'd0, slot_ff} < 32'(GROUPS));
   assign cur_g   = (kind_ff == KIND_FILTER) ? gp_ff : GW'(slot_ff);
   assign cur_n   = count_ff[cur_g];

   // lowest free slot
   always_comb begin
      free_g = '0;
      free_ok = 1'b0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (!valid_ff[g]) begin
            free_g = GW'(g);
            free_ok = 1'b1;
         end
      end
   end

   assign sts.kind       = kind_ff;
   assign sts.grp_last   = (32'(gp_ff) == 32'(GROUPS - 1));
   assign sts.grp_match  = valid_ff[gp_ff] && (gaddr_ff[gp_ff] == ga_ff);
   assign sts.src_done   = !rd_ok_ff && (sp_ff >= cur_n);
   assign sts.src_match  = rd_ok_ff && (rd_ff == sa_ff);
   assign sts.slot_ok    = slot_ok;
   // shift ends once the last fetched entry has been written back
   assign sts.shift_done = !rd_ok_ff && (sp_ff >= cur_n);

   // a group's filter scan ends at a match or at the count
   assign verdict = scan_ff && (sts.src_done || sts.src_match);

   // read address: entry 0 on a restart, else the pointer into the current list
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] sp_idx;
   logic          rd_en;
   logic [CW-1:0] sh_pos;
   assign sp_idx  = cmd.src_clear ? '0 : sp_ff[SW-1:0];
   assign rd_addr = (AW'(cur_g) * AW'(SOURCES)) + AW'(sp_idx);
   assign rd_en   = cmd.src_clear ? (cur_n != '0)
                  : ((cmd.src_step || cmd.shift_step) && (sp_ff < cur_n));
   assign sh_pos  = sp_ff - CW'(2);

   // source memory: registered read, single write
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = (AW'(cur_g) * AW'(SOURCES)) + AW'(cur_n[SW-1:0]);
      wr_data = sa_ff;
      if (cmd.shift_step && rd_ok_ff) begin
         wr_en = 1'b1;
         wr_addr = (AW'(cur_g) * AW'(SOURCES)) + AW'(sh_pos[SW-1:0]);
         wr_data = rd_ff;
      end else if (cmd.commit && kind_ff == KIND_ADD && slot_ok && !found_ff
                   && cur_n < CW'(SOURCES)) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) src_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= src_mem[rd_addr];
   end

   // scan and result bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         mode_ff  <= '1;
         for (int g = 0; g < GROUPS; g++) count_ff[g] <= '0;
         rd_ok_ff <= 1'b0;
         gp_ff <= '0;
         sp_ff <= '0;
         found_ff <= 1'b0;
         scan_ff <= 1'b0;
         accept_ff <= 1'b0;
         hit_ff <= 1'b0;
         hslot_ff <= '0;
      end else begin
         if (cmd.load) begin
            kind_ff <= req_kind;
            ga_ff   <= req_group_address;
            sa_ff   <= req_source_address;
            slot_ff <= req_group_slot;
            fm_ff   <= req_filter_mode;
         end
         // advance the group pointer
         if (cmd.load) gp_ff <= '0;
         else if (cmd.grp_step) gp_ff <= gp_ff + GW'(1);
         // advance the source pointer, one ahead of the read data
         if (cmd.load) begin
            sp_ff <= '0;
            rd_ok_ff <= 1'b0;
         end else if (cmd.src_clear) begin
            sp_ff <= (cur_n != '0) ? CW'(1) : '0;
            rd_ok_ff <= (cur_n != '0);
         end else if (cmd.src_step || cmd.shift_step) begin
            if (sp_ff < cur_n) sp_ff <= sp_ff + CW'(1);
            rd_ok_ff <= (sp_ff < cur_n);
         end else if (sts.src_match && kind_ff != KIND_FILTER) begin
            // hold the pointer past the match for the remove shift
            rd_ok_ff <= 1'b0;
         end
         // search hit for add/remove
         if (cmd.load || cmd.src_clear) found_ff <= 1'b0;
         else if (sts.src_match && kind_ff != KIND_FILTER) found_ff <= 1'b1;
         // track one group's filter scan
         if (cmd.load) scan_ff <= 1'b0;
         else if (cmd.src_clear) scan_ff <= (kind_ff == KIND_FILTER);
         else if (verdict) scan_ff <= 1'b0;
         // filter verdict once a group's scan ends
         if (cmd.load) begin
            accept_ff <= 1'b0;
            hit_ff  <= 1'b0;
            hslot_ff <= '0;
         end else if (verdict) begin
            hit_ff <= 1'b1;
            hslot_ff <= 2'(gp_ff);
            if (mode_ff[gp_ff]) accept_ff <= !sts.src_match;
            else if (sts.src_match) accept_ff <= 1'b1;
         end
         if (cmd.commit) begin
            case (kind_ff)
               KIND_CREATE: if (free_ok) begin
                  valid_ff[free_g] <= 1'b1;
                  gaddr_ff[free_g] <= ga_ff;
                  mode_ff[free_g]  <= 1'b1;
                  count_ff[free_g] <= '0;
               end
               KIND_DELETE: if (slot_ok) valid_ff[cur_g] <= 1'b0;
               KIND_ADD: if (slot_ok && !found_ff && cur_n < CW'(SOURCES))
                  count_ff[cur_g] <= cur_n + CW'(1);
               KIND_REMOVE: if (slot_ok && found_ff)
                  count_ff[cur_g] <= cur_n - CW'(1);
               KIND_MODE: if (slot_ok) mode_ff[cur_g] <= fm_ff;
               default: ;
            endcase
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_accept   <= (kind_ff == KIND_FILTER) && accept_ff;
         rsp_status   <= ((kind_ff == KIND_CREATE) && !free_ok)
                      || ((kind_ff == KIND_ADD) && slot_ok && !found_ff
                          && cur_n >= CW'(SOURCES));
         rsp_hit      <= ((kind_ff == KIND_FILTER) && hit_ff)
                      || ((kind_ff == KIND_CREATE) && free_ok);
         rsp_slot_out <= (kind_ff == KIND_FILTER) ? (hit_ff ? hslot_ff : 2'd0)
                       : ((kind_ff == KIND_CREATE && free_ok) ? 2'(free_g) : 2'd0);
      end
   end
endmodule
`default_nettype wire

// ----- hdl/multicast_source_filter_table.sv -----
// Sequence: create, delete and set mode go from the group step straight to finish; a filter
// steps through every group and scans the source list of each matching group, then finishes.
// Add with a slot in range scans the list for the source; remove scans it, then shifts later entries down.
// Throughput: one request at a time; the next is accepted the cycle after the result loads.
// Reset: synchronous; clears all groups, modes to exclude, counts to zero.
// Source memory is not cleared; entries are read only below the count.
`default_nettype none
module multicast_source_filter_table #(
   parameter int GROUPS  = msft_pkg::GroupsDefault,
   parameter int SOURCES = msft_pkg::SourcesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_group_address,
   input  wire logic [31:0] req_source_address,
   input  wire logic [1:0]  req_group_slot,
   input  wire logic        req_filter_mode,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_accept,
   output logic             rsp_status,
   output logic             rsp_hit,
   output logic [1:0]       rsp_slot_out
);
   import msft_pkg::*;

   cmd_type cmd;
   sts_type sts;

   msft_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   msft_dp #(.GROUPS(GROUPS), .SOURCES(SOURCES)) u_dp (
      .clock(clock), .reset(reset),
      .req_kind(req_kind), .req_group_address(req_group_address),
      .req_source_address(req_source_address), .req_group_slot(req_group_slot),
      .req_filter_mode(req_filter_mode),
      .cmd(cmd), .sts(sts),
      .rsp_accept(rsp_accept), .rsp_status(rsp_status),
      .rsp_hit(rsp_hit), .rsp_slot_out(rsp_slot_out)
   );
endmodule
`default_nettype wire
